[rtl/esc_pkg.sv]
package esc_pkg;

   localparam int unsigned EPOCH_W   = 32;
   localparam int unsigned PROD_W    = 64;
   localparam int unsigned REM_W     = 17;
   localparam int unsigned DAYS_W    = 16;
   localparam int unsigned YEAR_W    = 12;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned DAY_W     = 5;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MINUTE_W  = 6;
   localparam int unsigned SECOND_W  = 6;
   localparam int unsigned WEEKDAY_W = 3;

   localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [REM_W-1:0] SECS_PER_MIN  = 17'd60;
   localparam logic [REM_W-1:0] DAYS_PER_WEEK = 17'd7;

   // floor(2^SHIFT / divisor); the estimate is the quotient or one below it
   localparam logic [EPOCH_W-1:0] RECIP_DAY  = 32'd3257812230;
   localparam logic [EPOCH_W-1:0] RECIP_WEEK = 32'd2454267026;
   localparam logic [EPOCH_W-1:0] RECIP_HOUR = 32'd2443359172;
   localparam logic [EPOCH_W-1:0] RECIP_MIN  = 32'd2290649224;
   localparam int unsigned        SHIFT_DAY  = 48;
   localparam int unsigned        SHIFT_WEEK = 34;
   localparam int unsigned        SHIFT_HOUR = 43;
   localparam int unsigned        SHIFT_MIN  = 37;

   localparam logic [DAYS_W-1:0] BASE_WEEKDAY = 16'd3;
   localparam logic [YEAR_W-1:0] BASE_YEAR    = 12'd2020;
   localparam logic [1:0]        BASE_Y4      = 2'd0;
   localparam logic [6:0]        BASE_Y100    = 7'd20;
   localparam logic [8:0]        BASE_Y400    = 9'd20;
   localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD_DAY,
      OP_MUL_RECIP,
      OP_MUL_BACK,
      OP_SUB,
      OP_FIX,
      OP_LOAD_WEEK,
      OP_LOAD_HOUR,
      OP_LOAD_MIN,
      OP_LOAD_YEAR,
      OP_YEAR_STEP,
      OP_MONTH_STEP,
      OP_PUBLISH
   } dp_op_type;

   typedef enum logic [1:0] {
      DIV_DAY,
      DIV_WEEK,
      DIV_HOUR,
      DIV_MIN
   } div_sel_type;

   typedef enum logic [1:0] {
      PH_MUL_RECIP,
      PH_MUL_BACK,
      PH_SUB,
      PH_FIX
   } div_phase_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_DAY,
      ST_LOAD_WEEK,
      ST_DIV_WEEK,
      ST_LOAD_HOUR,
      ST_DIV_HOUR,
      ST_LOAD_MIN,
      ST_DIV_MIN,
      ST_LOAD_YEAR,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } ctrl_state_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[rtl/esc_ctrl.sv]
module esc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output esc_pkg::dp_cmd_type    cmd,
   input  esc_pkg::dp_status_type status
);
   import esc_pkg::*;

   ctrl_state_type   state_ff, state_in;
   div_phase_type    phase_ff, phase_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_MUL_RECIP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = OP_NOP;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD_DAY;
               phase_in = PH_MUL_RECIP;
               state_in = ST_DIV_DAY;
            end
         end
         ST_DIV_DAY, ST_DIV_WEEK, ST_DIV_HOUR, ST_DIV_MIN: begin
            case (phase_ff)
               PH_MUL_RECIP: begin
                  cmd.op   = OP_MUL_RECIP;
                  phase_in = PH_MUL_BACK;
               end
               PH_MUL_BACK: begin
                  cmd.op   = OP_MUL_BACK;
                  phase_in = PH_SUB;
               end
               PH_SUB: begin
                  cmd.op   = OP_SUB;
                  phase_in = PH_FIX;
               end
               default: begin
                  cmd.op   = OP_FIX;
                  phase_in = PH_MUL_RECIP;
                  case (state_ff)
                     ST_DIV_DAY:  state_in = ST_LOAD_WEEK;
                     ST_DIV_WEEK: state_in = ST_LOAD_HOUR;
                     ST_DIV_HOUR: state_in = ST_LOAD_MIN;
                     default:     state_in = ST_LOAD_YEAR;
                  endcase
               end
            endcase
         end
         ST_LOAD_WEEK: begin
            cmd.op   = OP_LOAD_WEEK;
            phase_in = PH_MUL_RECIP;
            state_in = ST_DIV_WEEK;
         end
         ST_LOAD_HOUR: begin
            cmd.op   = OP_LOAD_HOUR;
            phase_in = PH_MUL_RECIP;
            state_in = ST_DIV_HOUR;
         end
         ST_LOAD_MIN: begin
            cmd.op   = OP_LOAD_MIN;
            phase_in = PH_MUL_RECIP;
            state_in = ST_DIV_MIN;
         end
         ST_LOAD_YEAR: begin
            cmd.op   = OP_LOAD_YEAR;
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            cmd.op = OP_YEAR_STEP;
            if (status.year_done) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            cmd.op = OP_MONTH_STEP;
            if (status.month_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIV_DAY && phase_ff == PH_MUL_RECIP))
      else $error("accepted word did not start the day division");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |=> rsp_valid_ff)
      else $error("published result not marked valid");

   a_day_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_DAY && phase_ff == PH_FIX) |=> (state_ff == ST_LOAD_WEEK))
      else $error("day division did not end after its last step");

endmodule

[rtl/esc_dp.sv]
module esc_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [esc_pkg::EPOCH_W-1:0]           req_epoch_seconds,
   input  esc_pkg::dp_cmd_type                   cmd,
   output esc_pkg::dp_status_type                status,
   output logic [esc_pkg::YEAR_W-1:0]            rsp_year,
   output logic [esc_pkg::MONTH_W-1:0]           rsp_month,
   output logic [esc_pkg::DAY_W-1:0]             rsp_day,
   output logic [esc_pkg::HOUR_W-1:0]            rsp_hour,
   output logic [esc_pkg::MINUTE_W-1:0]          rsp_minute,
   output logic [esc_pkg::SECOND_W-1:0]          rsp_second,
   output logic [esc_pkg::WEEKDAY_W-1:0]         rsp_weekday
);
   import esc_pkg::*;

   logic [EPOCH_W-1:0]   x_ff, x_in;
   div_sel_type          sel_ff, sel_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [DAYS_W-1:0]    quo_ff, quo_in;
   logic [EPOCH_W-1:0]   qd_ff, qd_in;
   logic [REM_W:0]       rem_ff, rem_in;
   logic [DAYS_W-1:0]    days_ff, days_in;
   logic [REM_W-1:0]     tod_ff, tod_in;
   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [1:0]           y4_ff, y4_in;
   logic [6:0]           y100_ff, y100_in;
   logic [8:0]           y400_ff, y400_in;
   logic [WEEKDAY_W-1:0] weekday_ff, weekday_in;
   logic [HOUR_W-1:0]    hour_ff, hour_in;
   logic [MINUTE_W-1:0]  minute_ff, minute_in;
   logic [SECOND_W-1:0]  second_ff, second_in;

   logic [YEAR_W-1:0]    out_year_ff, out_year_in;
   logic [MONTH_W-1:0]   out_month_ff, out_month_in;
   logic [DAY_W-1:0]     out_day_ff, out_day_in;
   logic [HOUR_W-1:0]    out_hour_ff, out_hour_in;
   logic [MINUTE_W-1:0]  out_minute_ff, out_minute_in;
   logic [SECOND_W-1:0]  out_second_ff, out_second_in;
   logic [WEEKDAY_W-1:0] out_weekday_ff, out_weekday_in;

   logic [REM_W-1:0]        divisor;
   logic [EPOCH_W-1:0]      recip;
   logic [DAYS_W-1:0]       quo_est;
   logic [PROD_W-1:0]       prod_full;
   logic [DAYS_W+REM_W-1:0] qd_full;
   logic [EPOCH_W-1:0]      diff;
   logic                    fix_ge;
   logic                    leap;
   logic [8:0]              ylen;
   logic [DAY_W-1:0]        mlen;
   logic [DAYS_W-1:0]       week_base;

   always_comb begin
      case (sel_ff)
         DIV_DAY: begin
            divisor = SECS_PER_DAY;
            recip   = RECIP_DAY;
            quo_est = prod_ff[SHIFT_DAY +: DAYS_W];
         end
         DIV_WEEK: begin
            divisor = DAYS_PER_WEEK;
            recip   = RECIP_WEEK;
            quo_est = prod_ff[SHIFT_WEEK +: DAYS_W];
         end
         DIV_HOUR: begin
            divisor = SECS_PER_HOUR;
            recip   = RECIP_HOUR;
            quo_est = prod_ff[SHIFT_HOUR +: DAYS_W];
         end
         default: begin
            divisor = SECS_PER_MIN;
            recip   = RECIP_MIN;
            quo_est = prod_ff[SHIFT_MIN +: DAYS_W];
         end
      endcase
      prod_full = {{EPOCH_W{1'b0}}, x_ff} * {{EPOCH_W{1'b0}}, recip};
      qd_full   = {{REM_W{1'b0}}, quo_est} * {{DAYS_W{1'b0}}, divisor};
      diff      = x_ff - qd_ff;
      fix_ge    = rem_ff >= {1'b0, divisor};
      leap      = ((y4_ff == 2'd0) && (y100_ff != 7'd0)) || (y400_ff == 9'd0);
      ylen      = leap ? 9'd366 : 9'd365;
      mlen      = month_days(month_ff, leap);
      week_base = quo_ff + BASE_WEEKDAY;
      status.year_done  = days_ff < {7'd0, ylen};
      status.month_done = (month_ff == LAST_MONTH) || (days_ff < {11'd0, mlen});
   end

   always_comb begin
      x_in           = x_ff;
      sel_in         = sel_ff;
      prod_in        = prod_ff;
      quo_in         = quo_ff;
      qd_in          = qd_ff;
      rem_in         = rem_ff;
      days_in        = days_ff;
      tod_in         = tod_ff;
      year_in        = year_ff;
      month_in       = month_ff;
      y4_in          = y4_ff;
      y100_in        = y100_ff;
      y400_in        = y400_ff;
      weekday_in     = weekday_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      out_year_in    = out_year_ff;
      out_month_in   = out_month_ff;
      out_day_in     = out_day_ff;
      out_hour_in    = out_hour_ff;
      out_minute_in  = out_minute_ff;
      out_second_in  = out_second_ff;
      out_weekday_in = out_weekday_ff;
      case (cmd.op)
         OP_LOAD_DAY: begin
            x_in   = req_epoch_seconds;
            sel_in = DIV_DAY;
         end
         OP_MUL_RECIP: begin
            prod_in = prod_full;
         end
         OP_MUL_BACK: begin
            quo_in = quo_est;
            qd_in  = qd_full[EPOCH_W-1:0];
         end
         OP_SUB: begin
            rem_in = diff[REM_W:0];
         end
         OP_FIX: begin
            if (fix_ge) begin
               quo_in = quo_ff + 16'd1;
               rem_in = rem_ff - {1'b0, divisor};
            end
         end
         OP_LOAD_WEEK: begin
            days_in = quo_ff;
            tod_in  = rem_ff[REM_W-1:0];
            x_in    = {16'd0, week_base};
            sel_in  = DIV_WEEK;
         end
         OP_LOAD_HOUR: begin
            weekday_in = rem_ff[WEEKDAY_W-1:0];
            x_in       = {15'd0, tod_ff};
            sel_in     = DIV_HOUR;
         end
         OP_LOAD_MIN: begin
            hour_in = quo_ff[HOUR_W-1:0];
            x_in    = {20'd0, rem_ff[11:0]};
            sel_in  = DIV_MIN;
         end
         OP_LOAD_YEAR: begin
            minute_in = quo_ff[MINUTE_W-1:0];
            second_in = rem_ff[SECOND_W-1:0];
            year_in   = BASE_YEAR;
            month_in  = 4'd1;
            y4_in     = BASE_Y4;
            y100_in   = BASE_Y100;
            y400_in   = BASE_Y400;
         end
         OP_YEAR_STEP: begin
            if (!status.year_done) begin
               days_in = days_ff - {7'd0, ylen};
               year_in = year_ff + 12'd1;
               y4_in   = y4_ff + 2'd1;
               y100_in = (y100_ff == 7'd99) ? 7'd0 : y100_ff + 7'd1;
               y400_in = (y400_ff == 9'd399) ? 9'd0 : y400_ff + 9'd1;
            end
         end
         OP_MONTH_STEP: begin
            if (!status.month_done) begin
               days_in  = days_ff - {11'd0, mlen};
               month_in = month_ff + 4'd1;
            end
         end
         OP_PUBLISH: begin
            out_year_in    = year_ff;
            out_month_in   = month_ff;
            out_day_in     = days_ff[DAY_W-1:0] + 5'd1;
            out_hour_in    = hour_ff;
            out_minute_in  = minute_ff;
            out_second_in  = second_ff;
            out_weekday_in = weekday_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      sel_ff         <= sel_in;
      prod_ff        <= prod_in;
      quo_ff         <= quo_in;
      qd_ff          <= qd_in;
      rem_ff         <= rem_in;
      days_ff        <= days_in;
      tod_ff         <= tod_in;
      year_ff        <= year_in;
      month_ff       <= month_in;
      y4_ff          <= y4_in;
      y100_ff        <= y100_in;
      y400_ff        <= y400_in;
      weekday_ff     <= weekday_in;
      hour_ff        <= hour_in;
      minute_ff      <= minute_in;
      second_ff      <= second_in;
      out_year_ff    <= out_year_in;
      out_month_ff   <= out_month_in;
      out_day_ff     <= out_day_in;
      out_hour_ff    <= out_hour_in;
      out_minute_ff  <= out_minute_in;
      out_second_ff  <= out_second_in;
      out_weekday_ff <= out_weekday_in;
   end

   assign rsp_year    = out_year_ff;
   assign rsp_month   = out_month_ff;
   assign rsp_day     = out_day_ff;
   assign rsp_hour    = out_hour_ff;
   assign rsp_minute  = out_minute_ff;
   assign rsp_second  = out_second_ff;
   assign rsp_weekday = out_weekday_ff;

   a_est_close: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SUB) |=> (rem_ff < {divisor, 1'b0}))
      else $error("quotient estimate more than one below");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FIX) |=> (rem_ff < {1'b0, divisor}))
      else $error("divider remainder reached the divisor");

   a_year_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_YEAR_STEP && !status.year_done) |=>
      (year_ff == $past(year_ff) + 12'd1 && year_ff <= 12'd2156))
      else $error("year walk stepped wrong");

   a_publish_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |=>
      (rsp_month >= 4'd1 && rsp_month <= LAST_MONTH && rsp_day != 5'd0 &&
       rsp_weekday <= 3'd6))
      else $error("published date out of range");

endmodule

[rtl/epoch_seconds_to_calendar_date.sv]
// Converts a 32-bit count of seconds since 2020-01-01 00:00:00 into the
// Gregorian date, time of day and weekday (0 = Sunday).
// Input channel req_*: one word carries req_epoch_seconds; req_ready is high
// only while the block is idle, so one word is converted at a time.
// Result channel rsp_*: one word per input word, held in an output register.
// The conversion time grows with Y, the number of whole years past 2020
// (0..136), and with M, the whole months past January (0..11).
// The steps are four constant divisions (days, weekday, hour and minute),
// each a reciprocal multiply, back multiply, subtract and correct step,
// with a load step after each, followed by the year walk and the
// month walk, one year or month per cycle.
// Reset clears the controller and rsp_valid; req_ready is high as soon as
// reset is released.
// When the receiver stalls, the result holds on rsp_* and the next word may
// be accepted and converted; its result waits until the held word is taken.
module epoch_seconds_to_calendar_date (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [esc_pkg::EPOCH_W-1:0]   req_epoch_seconds,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [esc_pkg::YEAR_W-1:0]    rsp_year,
   output logic [esc_pkg::MONTH_W-1:0]   rsp_month,
   output logic [esc_pkg::DAY_W-1:0]     rsp_day,
   output logic [esc_pkg::HOUR_W-1:0]    rsp_hour,
   output logic [esc_pkg::MINUTE_W-1:0]  rsp_minute,
   output logic [esc_pkg::SECOND_W-1:0]  rsp_second,
   output logic [esc_pkg::WEEKDAY_W-1:0] rsp_weekday
);
   import esc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   esc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_epoch_seconds (req_epoch_seconds),
      .cmd               (cmd),
      .status            (status),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

endmodule

[test/calendar_date_checker.sv]
module calendar_date_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [esc_pkg::EPOCH_W-1:0]   req_epoch_seconds,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [esc_pkg::YEAR_W-1:0]    rsp_year,
   input  logic [esc_pkg::MONTH_W-1:0]   rsp_month,
   input  logic [esc_pkg::DAY_W-1:0]     rsp_day,
   input  logic [esc_pkg::HOUR_W-1:0]    rsp_hour,
   input  logic [esc_pkg::MINUTE_W-1:0]  rsp_minute,
   input  logic [esc_pkg::SECOND_W-1:0]  rsp_second,
   input  logic [esc_pkg::WEEKDAY_W-1:0] rsp_weekday,
   output int                            fail_count,
   output int                            pending,
   output int                            checked
);

   timeunit 1ns;
   timeprecision 1ps;

   import esc_pkg::*;

   localparam int unsigned DAY_SECS   = 86400;
   localparam int unsigned HOUR_SECS  = 3600;
   localparam int unsigned MIN_SECS   = 60;
   localparam int unsigned EPOCH_YEAR = 2020;
   localparam int unsigned EPOCH_WDAY = 3;
   localparam int          REPORT_MAX = 10;

   typedef struct packed {
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [HOUR_W-1:0]    hour;
      logic [MINUTE_W-1:0]  minute;
      logic [SECOND_W-1:0]  second;
      logic [WEEKDAY_W-1:0] weekday;
   } calendar_word_type;

   typedef struct {
      logic [EPOCH_W-1:0] secs;
      calendar_word_type  date;
   } expected_date_type;

   int unsigned common_month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   expected_date_type expected_dates [$];
   int                n_fail = 0;
   int                n_checked = 0;

   function automatic bit is_leap(input int unsigned yr);
      return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
      if (mo == 2 && is_leap(yr))
         return 29;
      return common_month_len[mo-1];
   endfunction

   function automatic calendar_word_type date_of_epoch(input logic [EPOCH_W-1:0] secs);
      calendar_word_type r;
      int unsigned       days;
      int unsigned       tod;
      int unsigned       yr;
      int unsigned       mo;
      days = secs / DAY_SECS;
      tod  = secs % DAY_SECS;
      r.weekday = WEEKDAY_W'((days + EPOCH_WDAY) % 7);
      yr = EPOCH_YEAR;
      while (days >= (is_leap(yr) ? 366 : 365)) begin
         days -= is_leap(yr) ? 366 : 365;
         yr++;
      end
      mo = 1;
      while (mo < 12 && days >= days_in_month(mo, yr)) begin
         days -= days_in_month(mo, yr);
         mo++;
      end
      r.year   = YEAR_W'(yr);
      r.month  = MONTH_W'(mo);
      r.day    = DAY_W'(days + 1);
      r.hour   = HOUR_W'(tod / HOUR_SECS);
      r.minute = MINUTE_W'((tod % HOUR_SECS) / MIN_SECS);
      r.second = SECOND_W'(tod % MIN_SECS);
      return r;
   endfunction

   always @(posedge clock) begin : watch_channels
      expected_date_type want;
      calendar_word_type got;
      if (reset) begin
         expected_dates.delete();
      end else begin
         if (req_valid && req_ready) begin
            want.secs = req_epoch_seconds;
            want.date = date_of_epoch(req_epoch_seconds);
            expected_dates.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second,
                    rsp_weekday};
            if (expected_dates.size() == 0) begin
               n_fail++;
               if (n_fail <= REPORT_MAX)
                  $display("%0t: unexpected word %0d-%0d-%0d %0d:%0d:%0d wd %0d", $time,
                           got.year, got.month, got.day, got.hour, got.minute, got.second,
                           got.weekday);
            end else begin
               want = expected_dates.pop_front();
               n_checked++;
               if (got !== want.date) begin
                  n_fail++;
                  if (n_fail <= REPORT_MAX) begin
                     $display("%0t: %0d s: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d,",
                              $time, want.secs,
                              want.date.year, want.date.month, want.date.day,
                              want.date.hour, want.date.minute, want.date.second,
                              want.date.weekday);
                     $display("   got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                              got.year, got.month, got.day, got.hour, got.minute,
                              got.second, got.weekday);
                  end
               end
            end
         end
      end
      fail_count <= n_fail;
      checked    <= n_checked;
      pending    <= expected_dates.size();
   end

endmodule

[test/tb.sv]
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS   = 1200;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 600;
   localparam int DRAIN_CYCLES   = 250;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int unsigned DAY_SECS = 86400;
   localparam int unsigned LAST_DAY = 49709;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [esc_pkg::EPOCH_W-1:0]   req_epoch_seconds = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [esc_pkg::YEAR_W-1:0]    rsp_year;
   logic [esc_pkg::MONTH_W-1:0]   rsp_month;
   logic [esc_pkg::DAY_W-1:0]     rsp_day;
   logic [esc_pkg::HOUR_W-1:0]    rsp_hour;
   logic [esc_pkg::MINUTE_W-1:0]  rsp_minute;
   logic [esc_pkg::SECOND_W-1:0]  rsp_second;
   logic [esc_pkg::WEEKDAY_W-1:0] rsp_weekday;

   int fail_count;
   int pending;
   int checked;
   int words_sent = 0;
   int stall_cycles = 0;

   epoch_seconds_to_calendar_date dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

   calendar_date_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked           (checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [esc_pkg::EPOCH_W-1:0] secs_of(input int unsigned day_idx,
                                                          input int unsigned tod);
      return day_idx * DAY_SECS + tod;
   endfunction

   task automatic send_word(input logic [esc_pkg::EPOCH_W-1:0] secs, input int idx);
      int gap;
      gap = (idx % 200 < 40) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // leap day of 2020, year ends, the 2100 century rule and the top of the range
   logic [esc_pkg::EPOCH_W-1:0] directed_secs [] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      secs_of(58, 86399), secs_of(59, 0), secs_of(60, 0),
      secs_of(365, 86399), secs_of(366, 0),
      secs_of(424, 86399), secs_of(425, 0),
      secs_of(29219, 86399), secs_of(29220, 0), secs_of(29278, 86399), secs_of(29279, 0),
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555
   };

   initial begin : stimulus
      logic [esc_pkg::EPOCH_W-1:0] secs;
      int unsigned                 tod;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_secs[i])
         send_word(directed_secs[i], i + 40);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         case ($urandom_range(0, 9))
            4, 5, 6: begin
               case ($urandom_range(0, 2))
                  0:       tod = 0;
                  1:       tod = DAY_SECS - 1;
                  default: tod = $urandom_range(0, DAY_SECS - 1);
               endcase
               secs = secs_of($urandom_range(0, LAST_DAY), tod);
            end
            7:       secs = $urandom_range(0, 400 * DAY_SECS);
            8:       secs = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
            default: secs = $urandom;
         endcase
         send_word(secs, i);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words (field extremes, leap and century boundaries, random seconds)",
               words_sent);
      $display("Checked %0d dates, with one %0d-cycle result back-pressure stretch",
               checked, HOLD_CYCLES);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : take_results
      int gap;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         gap = (taken % 150 < 30) ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (taken == HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

[files.f]
rtl/esc_pkg.sv
rtl/esc_ctrl.sv
rtl/esc_dp.sv
rtl/epoch_seconds_to_calendar_date.sv
test/calendar_date_checker.sv
test/tb.sv
